[rtl/tpfp_pkg.sv]
// Shared types, format codes and constants for the tile pixel format packer.
`timescale 1ns / 1ps

package tpfp_pkg;

   localparam int GROUP_PIXELS = 8;

   typedef logic [7:0] pix_type;
   typedef pix_type [GROUP_PIXELS-1:0] pix_group_type;

   typedef enum logic [3:0] {
      FMT_RAW            = 4'd0,
      FMT_SWAP_PACKED    = 4'd1,
      FMT_PACKED         = 4'd2,
      FMT_INV_PLANAR     = 4'd3,
      FMT_INV_PLANAR_DBL = 4'd4,
      FMT_PACKED_LO      = 4'd5,
      FMT_PLANAR         = 4'd6,
      FMT_COL_REORDER    = 4'd7,
      FMT_DISCARD        = 4'd8
   } fmt_type;

   // Register indexes on the configuration port.
   localparam logic REG_FORMAT = 1'b0;
   localparam logic REG_WIDE   = 1'b1;

   // Last row of an 8x8 reorder tile.
   localparam logic [2:0] LAST_ROW = 3'd7;

   // Column pairs are sent out in this order in the reorder format.
   localparam logic [1:0] PAIR_ORDER [4] = '{2'd2, 2'd3, 2'd0, 2'd1};

endpackage

[rtl/tpfp_byte_fmt.sv]
// Combinational selection of one output byte of the held pixel group.
`timescale 1ns / 1ps

module tpfp_byte_fmt (
   input  tpfp_pkg::fmt_type       fmt,
   input  logic                    wide,
   input  logic [4:0]              idx,
   input  tpfp_pkg::pix_group_type pix,
   input  logic [31:0]             tile_row,
   output logic [7:0]              byte_out
);
   import tpfp_pkg::*;

   logic       use_hi;
   logic [1:0] pair;
   pix_type    first_pix;
   pix_type    second_pix;
   logic [7:0] packed_b;
   logic [7:0] plane_b;
   logic [7:0] reorder_b;
   logic [1:0] src_pair;

   always_comb begin
      use_hi = wide && (fmt == FMT_SWAP_PACKED || fmt == FMT_PACKED);
      pair   = use_hi ? idx[2:1] : idx[1:0];
      if (fmt == FMT_SWAP_PACKED) begin
         first_pix  = pix[{pair, 1'b1}];
         second_pix = pix[{pair, 1'b0}];
      end else begin
         first_pix  = pix[{pair, 1'b0}];
         second_pix = pix[{pair, 1'b1}];
      end
      // With wide depth the odd bytes carry the high nibbles.
      if (use_hi && idx[0]) begin
         packed_b = {first_pix[7:4], second_pix[7:4]};
      end else begin
         packed_b = {first_pix[3:0], second_pix[3:0]};
      end
   end

   // The leftmost pixel lands in the most significant bit of a plane byte.
   always_comb begin
      for (int k = 0; k < GROUP_PIXELS; k++) begin
         plane_b[GROUP_PIXELS-1-k] = pix[k][idx[1:0]];
      end
   end

   always_comb begin
      src_pair  = PAIR_ORDER[idx[4:3]];
      reorder_b = {tile_row[{src_pair, 1'b1, 2'b00} +: 4],
                   tile_row[{src_pair, 1'b0, 2'b00} +: 4]};
   end

   always_comb begin
      case (fmt)
         FMT_RAW: begin
            byte_out = pix[idx[2:0]];
         end
         FMT_SWAP_PACKED, FMT_PACKED, FMT_PACKED_LO: begin
            byte_out = packed_b;
         end
         FMT_INV_PLANAR, FMT_INV_PLANAR_DBL: begin
            byte_out = ~plane_b;
         end
         FMT_PLANAR: begin
            byte_out = plane_b;
         end
         FMT_COL_REORDER: begin
            byte_out = reorder_b;
         end
         default: begin
            byte_out = 8'd0;
         end
      endcase
   end

endmodule

[rtl/tile_pixel_format_packer_top.sv]
// Top level of the tile pixel format packer: handshakes, tile store and output register.
`timescale 1ns / 1ps

// The first byte of a word passes the work register and then the output register before rsp_valid shows it.
// The byte sequencer sends one output byte per cycle while rsp_stall lets the output register
// drain; a word yields 4, 8 or 32 bytes, and a word that yields none never occupies the sequencer.
// The next word is taken in the cycle in which the last byte of the current one is sent.
// Reset (synchronous, active high) clears format_select, wide_depth, the tile row count
// and all valid flags; the tile row store is not cleared.
module tile_pixel_format_packer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pix0,
   input  logic [7:0]  req_pix1,
   input  logic [7:0]  req_pix2,
   input  logic [7:0]  req_pix3,
   input  logic [7:0]  req_pix4,
   input  logic [7:0]  req_pix5,
   input  logic [7:0]  req_pix6,
   input  logic [7:0]  req_pix7,
   input  logic        req_end_of_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import tpfp_pkg::*;

   logic [3:0]    fmt_ff, fmt_in;
   logic          wide_ff, wide_in;
   logic [2:0]    row_cnt_ff, row_cnt_in;
   logic [31:0]   tile_rows_ff [7];

   logic          work_vld_ff, work_vld_in;
   fmt_type       work_fmt_ff, work_fmt_in;
   logic          work_wide_ff, work_wide_in;
   pix_group_type work_pix_ff, work_pix_in;
   logic [4:0]    work_idx_ff, work_idx_in;
   logic [4:0]    work_last_ff, work_last_in;

   logic          rsp_vld_ff, rsp_vld_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;

   fmt_type       cur_fmt;
   pix_group_type req_pix;
   logic [31:0]   req_row;
   logic [31:0]   work_row;
   logic [31:0]   sel_row;
   logic          has_out;
   logic [4:0]    last_idx;
   logic          out_free;
   logic          advance;
   logic          work_done;
   logic          accept;
   logic          csr_wr;
   logic          row_wr;
   logic [7:0]    fmt_byte;

   assign req_pix = {req_pix7, req_pix6, req_pix5, req_pix4,
                     req_pix3, req_pix2, req_pix1, req_pix0};
   assign cur_fmt = fmt_type'(fmt_ff);

   always_comb begin
      for (int k = 0; k < GROUP_PIXELS; k++) begin
         req_row[4*k +: 4]  = req_pix[k][3:0];
         work_row[4*k +: 4] = work_pix_ff[k][3:0];
      end
   end

   // Configuration port.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_WIDE) ? {31'd0, wide_ff} : {28'd0, fmt_ff};

   always_comb begin
      fmt_in  = fmt_ff;
      wide_in = wide_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            REG_FORMAT: fmt_in  = pwdata[3:0];
            REG_WIDE:   wide_in = pwdata[0];
            default:    ;
         endcase
      end
   end

   // Number of bytes the incoming word yields, as a last index.
   always_comb begin
      has_out  = 1'b1;
      last_idx = 5'd3;
      unique case (cur_fmt)
         FMT_RAW:            last_idx = 5'd7;
         FMT_SWAP_PACKED,
         FMT_PACKED:         last_idx = wide_ff ? 5'd7 : 5'd3;
         FMT_INV_PLANAR_DBL: last_idx = 5'd7;
         FMT_INV_PLANAR,
         FMT_PACKED_LO,
         FMT_PLANAR:         last_idx = 5'd3;
         FMT_COL_REORDER: begin
            last_idx = 5'd31;
            has_out  = (row_cnt_ff == LAST_ROW);
         end
         default:            has_out = 1'b0;
      endcase
   end

   // Handshake.
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign advance   = work_vld_ff && out_free;
   assign work_done = advance && (work_idx_ff == work_last_ff);
   assign req_stall = work_vld_ff && !work_done;
   assign accept    = req_valid && !req_stall;
   assign row_wr    = accept && (cur_fmt == FMT_COL_REORDER) && (row_cnt_ff != LAST_ROW);

   always_comb begin
      row_cnt_in = row_cnt_ff;
      if (accept) begin
         if (cur_fmt == FMT_COL_REORDER) begin
            row_cnt_in = row_cnt_ff + 3'd1;
         end
         if (req_end_of_data) begin
            row_cnt_in = 3'd0;
         end
      end
   end

   always_comb begin
      work_vld_in  = work_vld_ff;
      work_fmt_in  = work_fmt_ff;
      work_wide_in = work_wide_ff;
      work_pix_in  = work_pix_ff;
      work_idx_in  = work_idx_ff;
      work_last_in = work_last_ff;
      if (accept && has_out) begin
         work_vld_in  = 1'b1;
         work_fmt_in  = cur_fmt;
         work_wide_in = wide_ff;
         work_pix_in  = req_pix;
         work_idx_in  = 5'd0;
         work_last_in = last_idx;
      end else if (work_done) begin
         work_vld_in = 1'b0;
      end else if (advance) begin
         work_idx_in = work_idx_ff + 5'd1;
      end
   end

   // Row seven of a reorder tile is the held word itself.
   assign sel_row = (work_idx_ff[2:0] == LAST_ROW) ? work_row : tile_rows_ff[work_idx_ff[2:0]];

   tpfp_byte_fmt u_byte_fmt (
      .fmt      (work_fmt_ff),
      .wide     (work_wide_ff),
      .idx      (work_idx_ff),
      .pix      (work_pix_ff),
      .tile_row (sel_row),
      .byte_out (fmt_byte)
   );

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      if (advance) begin
         rsp_vld_in  = 1'b1;
         rsp_byte_in = fmt_byte;
         rsp_last_in = (work_idx_ff == work_last_ff);
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff      <= 4'd0;
         wide_ff     <= 1'b0;
         row_cnt_ff  <= 3'd0;
         work_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         fmt_ff      <= fmt_in;
         wide_ff     <= wide_in;
         row_cnt_ff  <= row_cnt_in;
         work_vld_ff <= work_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      work_fmt_ff  <= work_fmt_in;
      work_wide_ff <= work_wide_in;
      work_pix_ff  <= work_pix_in;
      work_idx_ff  <= work_idx_in;
      work_last_ff <= work_last_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      if (row_wr) begin
         tile_rows_ff[row_cnt_ff] <= req_row;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

[verif/tb.sv]
// Self-checking testbench for the tile pixel format packer top level.
`timescale 1ns / 1ps

module tb;
   import tpfp_pkg::*;

   // Selector codes above the last defined format; the block treats them as discard.
   localparam logic [3:0] FMT_SPARE_LO = 4'd9;
   localparam logic [3:0] FMT_SPARE_HI = 4'd15;

   localparam logic [2:0] ADDR_FORMAT = {REG_FORMAT, 2'b00};
   localparam logic [2:0] ADDR_WIDE   = {REG_WIDE, 2'b00};

   localparam int ITEMS_PER_PHASE = 45;
   localparam int LONG_HOLD       = 100;
   localparam int DRAIN_CYCLES    = 4;

   typedef struct {
      pix_group_type pix;
      logic          eod;
   } group_word_type;

   typedef struct {
      logic [7:0] value;
      logic       last;
   } out_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_pix0 = '0;
   logic [7:0]  req_pix1 = '0;
   logic [7:0]  req_pix2 = '0;
   logic [7:0]  req_pix3 = '0;
   logic [7:0]  req_pix4 = '0;
   logic [7:0]  req_pix5 = '0;
   logic [7:0]  req_pix6 = '0;
   logic [7:0]  req_pix7 = '0;
   logic        req_end_of_data = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   tile_pixel_format_packer_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pix0        (req_pix0),
      .req_pix1        (req_pix1),
      .req_pix2        (req_pix2),
      .req_pix3        (req_pix3),
      .req_pix4        (req_pix4),
      .req_pix5        (req_pix5),
      .req_pix6        (req_pix6),
      .req_pix7        (req_pix7),
      .req_end_of_data (req_end_of_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("== FAIL ==");
      $finish;
   end

   group_word_type pend_words[$];
   out_byte_type   expected_bytes[$];
   group_word_type word_on_bus;

   // Mirror of the block's state and registers.
   logic [31:0] tile_store [7];
   logic [2:0]  tile_row = '0;
   logic [3:0]  fmt_reg = FMT_RAW;
   logic        wide_reg = 1'b0;

   int  send_idle = 18;
   int  recv_idle = 50;
   int  fail_count = 0;
   bit  hold_req = 1'b0;
   int  hold_left = 0;

   function automatic logic [7:0] plane_of(input pix_group_type px, input int plane);
      logic [7:0] acc;
      acc = '0;
      for (int k = 0; k < GROUP_PIXELS; k++) acc = {acc[6:0], px[k][plane]};
      return acc;
   endfunction

   // Works out the bytes that one accepted word yields and queues them.
   function automatic void pack_group(input group_word_type w);
      logic [7:0]  bytes [32];
      int          n;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [31:0] cur;
      logic [31:0] rv;
      int          src;
      out_byte_type ob;
      n = 0;
      cur = '0;
      case (fmt_reg)
         FMT_RAW: begin
            for (int k = 0; k < GROUP_PIXELS; k++) bytes[n++] = w.pix[k];
         end
         FMT_SWAP_PACKED, FMT_PACKED, FMT_PACKED_LO: begin
            for (int p = 0; p < GROUP_PIXELS / 2; p++) begin
               a = (fmt_reg == FMT_SWAP_PACKED) ? w.pix[2*p+1] : w.pix[2*p];
               b = (fmt_reg == FMT_SWAP_PACKED) ? w.pix[2*p] : w.pix[2*p+1];
               bytes[n++] = {a[3:0], b[3:0]};
               if (wide_reg && fmt_reg != FMT_PACKED_LO) bytes[n++] = {a[7:4], b[7:4]};
            end
         end
         FMT_INV_PLANAR, FMT_INV_PLANAR_DBL, FMT_PLANAR: begin
            for (int rep = 0; rep < ((fmt_reg == FMT_INV_PLANAR_DBL) ? 2 : 1); rep++) begin
               for (int pl = 0; pl < 4; pl++) begin
                  bytes[n++] = (fmt_reg == FMT_PLANAR) ? plane_of(w.pix, pl)
                                                       : ~plane_of(w.pix, pl);
               end
            end
         end
         FMT_COL_REORDER: begin
            for (int k = 0; k < GROUP_PIXELS; k++) cur[4*k +: 4] = w.pix[k][3:0];
            if (tile_row < LAST_ROW) begin
               tile_store[tile_row] = cur;
               tile_row = tile_row + 3'd1;
            end else begin
               for (int cs = 0; cs < 4; cs++) begin
                  src = 2 * int'(PAIR_ORDER[cs]);
                  for (int row = 0; row < 8; row++) begin
                     rv = (row < LAST_ROW) ? tile_store[row] : cur;
                     bytes[n++] = {rv[4*(src+1) +: 4], rv[4*src +: 4]};
                  end
               end
               tile_row = '0;
            end
         end
         default: ;
      endcase
      if (w.eod) tile_row = '0;
      for (int i = 0; i < n; i++) begin
         ob.value = bytes[i];
         ob.last  = (i == n - 1);
         expected_bytes.push_back(ob);
      end
   endfunction

   // Driver: a new word goes on the bus only once the previous one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) pack_group(word_on_bus);
         if (!req_valid || !req_stall) begin
            if (pend_words.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
               word_on_bus = pend_words.pop_front();
               req_pix0 <= word_on_bus.pix[0];
               req_pix1 <= word_on_bus.pix[1];
               req_pix2 <= word_on_bus.pix[2];
               req_pix3 <= word_on_bus.pix[3];
               req_pix4 <= word_on_bus.pix[4];
               req_pix5 <= word_on_bus.pix[5];
               req_pix6 <= word_on_bus.pix[6];
               req_pix7 <= word_on_bus.pix[7];
               req_end_of_data <= word_on_bus.eod;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each taken byte and decides the stall for the next cycle.
   always @(posedge clock) begin : monitor
      out_byte_type want;
      logic         stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected byte %h with no expectation waiting", rsp_out_byte);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.value) begin
                  $error("out_byte: expected %h, actual %h", want.value, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_last_of_run !== want.last) begin
                  $error("last_of_run: expected %b, actual %b", want.last, rsp_last_of_run);
                  fail_count++;
               end
            end
         end
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            stall_next = ($urandom_range(0, 99) < recv_idle);
         end
         rsp_stall <= stall_next;
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      if (addr == ADDR_FORMAT) fmt_reg = data[3:0];
      else if (addr == ADDR_WIDE) wide_reg = data[0];
   endtask

   task automatic set_format(input logic [3:0] fmt, input logic wide);
      csr_write(ADDR_FORMAT, {28'd0, fmt});
      csr_write(ADDR_WIDE, {31'd0, wide});
   endtask

   // Holds the sender until every queued word is taken and every byte is back.
   // Words that yield nothing give no sign of completion, so the task then waits out DRAIN_CYCLES.
   task automatic wait_drained();
      @(negedge clock);
      while (pend_words.size() > 0 || req_valid || expected_bytes.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic push_word(input pix_group_type pix, input logic eod);
      group_word_type w;
      w.pix = pix;
      w.eod = eod;
      pend_words.push_back(w);
   endtask

   function automatic pix_group_type rand_group();
      pix_group_type g;
      for (int k = 0; k < GROUP_PIXELS; k++) begin
         case ($urandom_range(0, 9))
            0:       g[k] = 8'h00;
            1:       g[k] = 8'hFF;
            default: g[k] = 8'($urandom_range(0, 255));
         endcase
      end
      return g;
   endfunction

   initial begin : stimulus
      int         phase_items;
      int         cut;
      bit         broken;
      logic [3:0] fmt;
      int         pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words. Group literals list pix7 first and pix0 last.
      push_word(64'h0000_0000_0000_0000, 1'b0);
      push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      push_word(64'h8040_2010_0804_0201, 1'b1);
      wait_drained();
      set_format(FMT_SWAP_PACKED, 1'b0);
      push_word(64'hF0E1_D2C3_B4A5_9687, 1'b0);
      wait_drained();
      csr_write(ADDR_WIDE, 32'd1);
      push_word(64'hF0E1_D2C3_B4A5_9687, 1'b0);
      wait_drained();
      csr_write(ADDR_FORMAT, {28'd0, FMT_PACKED});
      push_word(64'h1E2D_3C4B_5A69_7887, 1'b0);
      wait_drained();
      csr_write(ADDR_WIDE, 32'd0);
      push_word(64'h1E2D_3C4B_5A69_7887, 1'b0);
      wait_drained();
      set_format(FMT_INV_PLANAR, 1'b1);
      push_word(64'h0F0E_0D0C_0B0A_0908, 1'b0);
      wait_drained();
      csr_write(ADDR_FORMAT, {28'd0, FMT_INV_PLANAR_DBL});
      push_word(64'h0706_0504_0302_0100, 1'b0);
      wait_drained();
      csr_write(ADDR_FORMAT, {28'd0, FMT_PACKED_LO});
      push_word(64'hFFEE_DDCC_BBAA_9988, 1'b0);
      wait_drained();
      csr_write(ADDR_FORMAT, {28'd0, FMT_PLANAR});
      push_word(64'h0F0E_0D0C_0B0A_0908, 1'b1);
      wait_drained();
      csr_write(ADDR_FORMAT, {28'd0, FMT_DISCARD});
      push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      wait_drained();
      csr_write(ADDR_FORMAT, {28'd0, FMT_SPARE_LO});
      push_word(rand_group(), 1'b0);
      wait_drained();
      csr_write(ADDR_FORMAT, {28'd0, FMT_SPARE_HI});
      push_word(rand_group(), 1'b1);
      wait_drained();

      // A tile cut short by the end flag gives no output.
      set_format(FMT_COL_REORDER, 1'b0);
      for (int r = 0; r < 3; r++) push_word(rand_group(), r == 2);
      // A tile interrupted by another format resumes from the kept row.
      for (int r = 0; r < 3; r++) push_word(rand_group(), 1'b0);
      wait_drained();
      csr_write(ADDR_FORMAT, {28'd0, FMT_RAW});
      push_word(rand_group(), 1'b0);
      wait_drained();
      csr_write(ADDR_FORMAT, {28'd0, FMT_COL_REORDER});
      for (int r = 0; r < 5; r++) push_word(rand_group(), 1'b0);

      for (int phase = 0; phase < 3; phase++) begin
         wait_drained();
         case (phase)
            0: begin send_idle = 18; recv_idle = 50; end
            1: begin send_idle = 50; recv_idle = 18; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         phase_items = 0;
         if (phase == 1) begin
            // Fill the block while the receiver holds off for a long stretch.
            set_format(FMT_INV_PLANAR_DBL, 1'b0);
            for (int i = 0; i < 12; i++) push_word(rand_group(), 1'b0);
            hold_req = 1'b1;
            phase_items += 12;
         end
         while (phase_items < ITEMS_PER_PHASE) begin
            wait_drained();
            pick = $urandom_range(0, 10);
            if (pick < 8) fmt = 4'(pick);
            else if (pick == 8) fmt = FMT_DISCARD;
            else if (pick == 9) fmt = FMT_COL_REORDER;
            else fmt = 4'($urandom_range(9, 15));
            set_format(fmt, 1'($urandom_range(0, 1)));
            if (fmt == FMT_COL_REORDER) begin
               repeat ($urandom_range(1, 2)) begin
                  broken = ($urandom_range(0, 3) == 0);
                  cut = broken ? $urandom_range(0, 6) : 7;
                  for (int r = 0; r <= cut; r++)
                     push_word(rand_group(), (r == cut) && (broken || $urandom_range(0, 1)));
                  phase_items += cut + 1;
               end
            end else begin
               repeat ($urandom_range(3, 8)) begin
                  push_word(rand_group(), $urandom_range(0, 7) == 0);
                  phase_items++;
               end
            end
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_bytes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[files.f]
rtl/tpfp_pkg.sv
rtl/tpfp_byte_fmt.sv
rtl/tile_pixel_format_packer_top.sv
verif/tb.sv
